/* hdl/etf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types, widths and the gradient table of the escape-time pixel unit.
// ----------------------------------------------------------------------------
package etf_pkg;

   localparam int FRAC_BITS  = 56;
   localparam int RE_W       = 131 - FRAC_BITS;
   localparam int RL         = (RE_W + 31) / 32;
   localparam int OPW        = RL * 32;
   localparam int ACC_W      = 64 * RL;
   localparam int LIW        = $clog2(RL);
   localparam int OFF_W      = $clog2(2 * RL);
   localparam int PW_W       = 192;
   localparam int CW         = ACC_W + PW_W + 2 * FRAC_BITS;
   localparam int COLOR_SPAN = 382;

   localparam logic [2:0] REG_MAX_ITER = 3'd0;
   localparam logic [2:0] REG_ESC_LIM  = 3'd1;

   typedef struct packed {
      logic signed [63:0] c_imag;
      logic signed [63:0] c_real;
   } etf_point_type;

   typedef struct packed {
      logic [16:0] escape_count;
      logic [8:0]  color_index;
   } etf_result_type;

   function automatic logic [23:0] gradient(input logic [8:0] idx);
      logic [7:0] j;
      logic [7:0] h;
      logic [23:0] rgb;
      j = {1'b0, idx[6:0]};
      h = (j + 8'd1) >> 1;
      unique case (idx[8:7])
         2'd0: rgb = {8'd0, 8'(2 * j), 8'(8'd64 + j)};
         2'd1: rgb = {h, 8'(8'd255 - h), 8'(8'd192 - j - h)};
         2'd2: rgb = {8'(8'd64 - h), 8'(8'd191 - j - h), h};
         default: rgb = 24'd0;
      endcase
      return rgb;
   endfunction

endpackage

/* hdl/etf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etf_queue
// Front end: accepts points and holds up to two of them for the engine.
// ----------------------------------------------------------------------------
module etf_queue import etf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  etf_point_type  in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output etf_point_type  out_item
);

   etf_point_type slot_ff [2];
   logic          head_ff, head_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;
   logic          tail;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign tail      = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail] <= in_item;
      end
   end

endmodule

/* hdl/etf_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etf_engine
// Back end: iterates z = z*z + c on one shared 32x32 multiplier and derives
// the smoothed escape count.
// ----------------------------------------------------------------------------
module etf_engine import etf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  etf_point_type   in_item,
   input  logic [15:0]     max_iter,
   input  logic [6:0]      esc_lim,
   output logic            res_valid,
   input  logic            res_ready,
   output etf_result_type  res_item
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_UPD  = 6'b000100,
      ST_CHK  = 6'b001000,
      ST_SMC  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef enum logic [5:0] {
      PH_SQA = 6'b000001,
      PH_SQB = 6'b000010,
      PH_AB  = 6'b000100,
      PH_SQR = 6'b001000,
      PH_SQI = 6'b010000,
      PH_SQP = 6'b100000
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic signed [63:0]     a_ff, a_in, b_ff, b_in, cr_ff, cr_in, ci_ff, ci_in;
   logic [127:0]           sqa_ff, sqa_in, sqb_ff, sqb_in, ab_ff, ab_in;
   logic signed [RE_W-1:0] re_ff, re_in, im_ff, im_in;
   logic [ACC_W-1:0]       acc_ff, acc_in, acc_sum, mag_ff, mag_in;
   logic [PW_W-1:0]        pw_ff, pw_in;
   logic                   pw_big_ff, pw_big_in;
   logic [63:0]            prod_ff, prod_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic                   pv_ff, pv_in, drain_ff, drain_in;
   logic [LIW-1:0]         i_ff, i_in, j_ff, j_in, nlast;
   logic [16:0]            kp1_ff, kp1_in, cnt_ff, cnt_in;
   logic [8:0]             kmod_ff, kmod_in, cmod_ff, cmod_in;
   logic [3:0]             m_ff, m_in;
   logic [63:0]            ua, ub;
   logic [RE_W-1:0]        ure, uim;
   logic [OPW-1:0]         xop, yop;
   logic [31:0]            xl, yl;
   logic signed [128:0]    diff, diff_sh, abs_v, ab_sh;
   logic [CW-1:0]          lim_v, pw_sh, mag_w;
   logic                   esc_ok;
   logic [16:0]            fin_cnt;
   logic [8:0]             fin_mod;

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_item  = '{escape_count: cnt_ff, color_index: cmod_ff};

   assign ua  = a_ff[63] ? 64'(-a_ff) : 64'(a_ff);
   assign ub  = b_ff[63] ? 64'(-b_ff) : 64'(b_ff);
   assign ure = re_ff[RE_W-1] ? RE_W'(-re_ff) : RE_W'(re_ff);
   assign uim = im_ff[RE_W-1] ? RE_W'(-im_ff) : RE_W'(im_ff);

   always_comb begin
      unique case (phase_ff)
         PH_SQA: begin xop = OPW'(ua);  yop = OPW'(ua); end
         PH_SQB: begin xop = OPW'(ub);  yop = OPW'(ub); end
         PH_AB:  begin xop = OPW'(ua);  yop = OPW'(ub); end
         PH_SQR: begin xop = OPW'(ure); yop = OPW'(ure); end
         PH_SQI: begin xop = OPW'(uim); yop = OPW'(uim); end
         PH_SQP: begin xop = OPW'(pw_ff[95:0]); yop = OPW'(pw_ff[95:0]); end
         default: begin xop = '0; yop = '0; end
      endcase
      nlast = (phase_ff == PH_SQA || phase_ff == PH_SQB || phase_ff == PH_AB) ?
              LIW'(1) : LIW'(RL - 1);
   end

   assign xl = xop[32*i_ff +: 32];
   assign yl = yop[32*j_ff +: 32];
   assign acc_sum = acc_ff + (pv_ff ? (ACC_W'(prod_ff) << {off_ff, 5'b0}) : '0);

   assign diff    = $signed({1'b0, sqa_ff}) - $signed({1'b0, sqb_ff});
   assign diff_sh = diff >>> FRAC_BITS;
   assign abs_v   = (a_ff[63] ^ b_ff[63]) ? -$signed({1'b0, ab_ff}) : $signed({1'b0, ab_ff});
   assign ab_sh   = abs_v >>> (FRAC_BITS - 1);

   assign lim_v = CW'(esc_lim) << (2 * FRAC_BITS);
   assign pw_sh = CW'(pw_ff) << (2 * FRAC_BITS);
   assign mag_w = CW'(mag_ff);

   always_comb begin
      esc_ok = (kp1_ff > {13'd0, m_ff});
      if (esc_ok) begin
         fin_cnt = kp1_ff - {13'd0, m_ff};
         fin_mod = (kmod_ff >= {5'd0, m_ff}) ? kmod_ff - {5'd0, m_ff} :
                   9'(kmod_ff + 9'(COLOR_SPAN) - {5'd0, m_ff});
      end else begin
         fin_cnt = 17'd1;
         fin_mod = 9'd1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      sqa_in    = sqa_ff;
      sqb_in    = sqb_ff;
      ab_in     = ab_ff;
      re_in     = re_ff;
      im_in     = im_ff;
      acc_in    = acc_sum;
      mag_in    = mag_ff;
      pw_in     = pw_ff;
      pw_big_in = pw_big_ff;
      prod_in   = prod_ff;
      off_in    = off_ff;
      pv_in     = 1'b0;
      drain_in  = drain_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      kp1_in    = kp1_ff;
      kmod_in   = kmod_ff;
      cnt_in    = cnt_ff;
      cmod_in   = cmod_ff;
      m_in      = m_ff;
      unique case (state_ff)
         ST_IDLE: begin
            acc_in = '0;
            if (in_valid) begin
               a_in     = in_item.c_real;
               b_in     = in_item.c_imag;
               cr_in    = in_item.c_real;
               ci_in    = in_item.c_imag;
               kp1_in   = 17'd1;
               kmod_in  = 9'd1;
               i_in     = '0;
               j_in     = '0;
               drain_in = 1'b0;
               phase_in = PH_SQA;
               if (max_iter == 16'd0) begin
                  cnt_in   = 17'd0;
                  cmod_in  = 9'd0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (!drain_ff) begin
               prod_in = 64'(xl) * 64'(yl);
               off_in  = OFF_W'(i_ff) + OFF_W'(j_ff);
               pv_in   = 1'b1;
               if (j_ff == nlast) begin
                  j_in = '0;
                  if (i_ff == nlast) begin
                     drain_in = 1'b1;
                  end else begin
                     i_in = i_ff + LIW'(1);
                  end
               end else begin
                  j_in = j_ff + LIW'(1);
               end
            end else begin
               drain_in = 1'b0;
               i_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               unique case (phase_ff)
                  PH_SQA: begin sqa_in = acc_sum[127:0]; phase_in = PH_SQB; end
                  PH_SQB: begin sqb_in = acc_sum[127:0]; phase_in = PH_AB; end
                  PH_AB: begin
                     ab_in    = acc_sum[127:0];
                     state_in = ST_UPD;
                  end
                  PH_SQR: begin acc_in = acc_sum; phase_in = PH_SQI; end
                  PH_SQI: begin mag_in = acc_sum; state_in = ST_CHK; end
                  PH_SQP: begin pw_in = acc_sum[PW_W-1:0]; state_in = ST_SMC; end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPD: begin
            re_in    = diff_sh[RE_W-1:0] + RE_W'(cr_ff);
            im_in    = ab_sh[RE_W-1:0] + RE_W'(ci_ff);
            phase_in = PH_SQR;
            state_in = ST_MUL;
         end
         ST_CHK: begin
            if (mag_w > lim_v) begin
               if (esc_lim < 7'd2) begin
                  cnt_in   = 17'd1;
                  cmod_in  = 9'd1;
                  state_in = ST_DONE;
               end else begin
                  pw_in     = PW_W'(esc_lim * esc_lim);
                  pw_big_in = 1'b0;
                  m_in      = 4'd0;
                  state_in  = ST_SMC;
               end
            end else if (kp1_ff == {1'b0, max_iter}) begin
               cnt_in   = 17'd0;
               cmod_in  = 9'd0;
               state_in = ST_DONE;
            end else begin
               kp1_in   = kp1_ff + 17'd1;
               kmod_in  = (kmod_ff == 9'(COLOR_SPAN - 1)) ? 9'd0 : kmod_ff + 9'd1;
               a_in     = re_ff[63:0];
               b_in     = im_ff[63:0];
               phase_in = PH_SQA;
               state_in = ST_MUL;
            end
         end
         ST_SMC: begin
            if (pw_big_ff || mag_w <= pw_sh) begin
               cnt_in   = fin_cnt;
               cmod_in  = fin_mod;
               state_in = ST_DONE;
            end else begin
               m_in = m_ff + 4'd1;
               if (pw_ff[PW_W-1:96] != '0) begin
                  pw_big_in = 1'b1;
               end else begin
                  phase_in = PH_SQP;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SQA;
         pv_ff    <= 1'b0;
         drain_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pv_ff    <= pv_in;
         drain_ff <= drain_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      sqa_ff    <= sqa_in;
      sqb_ff    <= sqb_in;
      ab_ff     <= ab_in;
      re_ff     <= re_in;
      im_ff     <= im_in;
      acc_ff    <= acc_in;
      mag_ff    <= mag_in;
      pw_ff     <= pw_in;
      pw_big_ff <= pw_big_in;
      prod_ff   <= prod_in;
      off_ff    <= off_in;
      kp1_ff    <= kp1_in;
      kmod_ff   <= kmod_in;
      cnt_ff    <= cnt_in;
      cmod_ff   <= cmod_in;
      m_ff      <= m_in;
   end

endmodule

/* hdl/escape_time_fractal_pixel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// Computes the smoothed escape count and gradient color of one point.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req_      in         c_real, c_imag
// rsp_      out        escape_count, red, green, blue
// csr_      in/out     max_iterations, escape_limit
//
// Each iteration runs on the single 32x32 multiplier. An escaping point adds
// up to six further squarings for smoothing. Reset is synchronous and
// initializes control state only. A two-entry queue takes new points while
// the engine works, and the result register lets the engine finish while a
// result waits.
module escape_time_fractal_pixel_unit import etf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // c_real, c_imag
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // escape_count, red, green, blue, zero pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [15:0]    max_iter_ff, max_iter_in;
   logic [6:0]     esc_lim_ff, esc_lim_in;
   logic           q_valid, q_ready, res_valid, res_ready;
   etf_point_type  q_item;
   etf_result_type res_item;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff, rsp_data_in;
   logic [23:0]    rgb;
   logic [2:0]     reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = {2'b00, csr_paddr[2]};

   always_comb begin
      max_iter_in = max_iter_ff;
      esc_lim_in  = esc_lim_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_MAX_ITER: max_iter_in = csr_pwdata[15:0];
            REG_ESC_LIM:  esc_lim_in  = csr_pwdata[6:0];
            default: ;
         endcase
      end
      unique case (reg_idx)
         REG_MAX_ITER: csr_prdata = {16'd0, max_iter_ff};
         REG_ESC_LIM:  csr_prdata = {25'd0, esc_lim_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   etf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_tdata),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   etf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .max_iter  (max_iter_ff),
      .esc_lim   (esc_lim_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item)
   );

   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign rgb        = (res_item.escape_count == 17'd0) ? 24'd0 :
                       gradient(res_item.color_index + 9'd1);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, rgb[7:0], rgb[15:8], rgb[23:16], res_item.escape_count};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= 16'd800;
         esc_lim_ff   <= 7'd5;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_iter_ff  <= max_iter_in;
         esc_lim_ff   <= esc_lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* test/tb_escape_time_fractal_pixel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel_unit
// Self-checking bench for the escape-time pixel unit. Points are streamed in
// under several idle and stall patterns and register settings, and every
// result is compared with a bit-exact wide-integer model of the iteration,
// the smoothed count and the color gradient.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel_unit;
   import etf_pkg::*;

   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [16:0] escape_count;
   } pixel_type;

   localparam logic signed [63:0] ONE = 64'sh0100_0000_0000_0000;
   localparam int STALL_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   etf_point_type point_queue[$];
   pixel_type     pixel_queue[$];
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            iter_cap = 800;
   int            esc_bound = 5;
   int            mismatches = 0;
   int            pixels_checked = 0;
   int            escaped_pixels = 0;
   int            quiet_cycles = 0;

   escape_time_fractal_pixel_unit i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [23:0] shade(input int idx);
      int j;
      int h;
      j = idx % 128;
      h = (j + 1) / 2;
      case (idx / 128)
         0: return {8'd0, 8'(2 * j), 8'(64 + j)};
         1: return {8'(h), 8'(255 - h), 8'(192 - j - h)};
         default: return {8'(64 - h), 8'(191 - j - h), 8'(h)};
      endcase
   endfunction

   function automatic pixel_type escape_pixel(input etf_point_type pt);
      logic signed [383:0] a;
      logic signed [383:0] b;
      logic signed [383:0] re;
      logic signed [383:0] im;
      logic signed [383:0] mag;
      logic signed [383:0] lim;
      logic [383:0]        pw;
      logic [63:0]         ar;
      logic [63:0]         br;
      int                  m;
      int                  cnt;
      logic [23:0]         rgb;
      pixel_type           px;
      ar = pt.c_real;
      br = pt.c_imag;
      cnt = 0;
      lim = 384'(esc_bound) << (2 * FRAC_BITS);
      for (int k = 0; k < iter_cap; k++) begin
         a = 384'(signed'(ar));
         b = 384'(signed'(br));
         re = ((a * a - b * b) >>> FRAC_BITS) + 384'(signed'(pt.c_real));
         im = ((a * b) >>> (FRAC_BITS - 1)) + 384'(signed'(pt.c_imag));
         mag = re * re + im * im;
         if (mag > lim) begin
            m = 0;
            if (esc_bound >= 2) begin
               pw = 384'(esc_bound * esc_bound);
               while ((pw >> 192) == 0 && !($unsigned(mag) <= (pw << (2 * FRAC_BITS)))) begin
                  pw = pw * pw;
                  m++;
               end
               cnt = (k + 1 > m) ? k + 1 - m : 1;
            end else begin
               cnt = 1;
            end
            break;
         end
         ar = re[63:0];
         br = im[63:0];
      end
      px = '0;
      if (cnt != 0) begin
         rgb = shade(cnt % COLOR_SPAN + 1);
         px.escape_count = 17'(cnt);
         {px.red, px.green, px.blue} = rgb;
      end
      return px;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= point_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response stall, prediction and checking.
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (req_tvalid && req_tready)
            pixel_queue.push_back(escape_pixel(etf_point_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[40:0];
            if (pixel_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected transfer %h", got);
            end else begin
               want = pixel_queue.pop_front();
               pixels_checked++;
               if (want.escape_count != 0)
                  escaped_pixels++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: count %0d rgb %h, expected count %0d rgb %h",
                              got.escape_count, {got.red, got.green, got.blue},
                              want.escape_count, {want.red, want.green, want.blue});
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (pixel_queue.size() == 0 && point_queue.size() == 0 && !req_tvalid))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("escape_time_fractal_pixel_unit regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [2:0] addr, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == 3'(4 * REG_MAX_ITER))
         iter_cap = value & 16'hFFFF;
      else
         esc_bound = value & 7'h7F;
   endtask

   task automatic configure(input int cap, input int bound);
      write_reg(3'(4 * REG_MAX_ITER), cap);
      write_reg(3'(4 * REG_ESC_LIM), bound);
   endtask

   task automatic drain();
      wait (point_queue.size() == 0 && !req_tvalid && pixel_queue.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_point(input logic signed [63:0] re, input logic signed [63:0] im);
      etf_point_type pt;
      pt.c_real = re;
      pt.c_imag = im;
      point_queue.push_back(pt);
   endtask

   function automatic logic signed [63:0] coord();
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(99) < 15)
         return v;
      return v >>> $urandom_range(5, 10);
   endfunction

   initial begin
      int cap;
      int bound;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default registers: bounded points, boundary points and field extremes.
      push_point(0, 0);
      push_point(-(ONE <<< 1), 0);
      push_point(ONE >>> 2, 0);
      push_point(0, ONE);
      push_point(64'sh7FFF_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF);
      push_point(64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000);
      push_point(64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF);
      push_point(ONE >>> 1, ONE >>> 1);
      push_point(-(ONE >>> 1) - (ONE >>> 2), ONE >>> 3);
      push_point(ONE <<< 1, 0);
      push_point(-1, -1);
      drain();

      configure(65535, 64);
      push_point(ONE * 10, 0);
      push_point(0, -(ONE * 9));
      push_point(ONE * 20, ONE * 20);
      drain();

      configure(0, 5);
      push_point(0, 0);
      push_point(ONE * 3, 0);
      drain();

      configure(10, 0);
      push_point(0, 0);
      push_point(ONE, ONE);
      drain();

      configure(10, 1);
      push_point(ONE, 0);
      push_point(ONE >>> 3, 0);
      drain();

      configure(1, 127);
      push_point(ONE * 12, 0);
      push_point(ONE >>> 1, -ONE);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(3))
            0: cap = $urandom_range(1, 3);
            1: cap = $urandom_range(4, 24);
            2: cap = 40;
            default: cap = $urandom_range(8, 16);
         endcase
         case ($urandom_range(4))
            0: bound = 2;
            1: bound = 64;
            2: bound = $urandom_range(0, 127);
            default: bound = $urandom_range(3, 8);
         endcase
         configure(cap, bound);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (int n = 0; n < 80; n++)
            push_point(coord(), coord());
         drain();
      end

      $display("Checked %0d pixels (%0d escaped) over directed points and 8 random phases.",
               pixels_checked, escaped_pixels);
      if (mismatches == 0)
         $display("escape_time_fractal_pixel_unit regression: pass");
      else
         $display("escape_time_fractal_pixel_unit regression: fail");
      $finish;
   end

endmodule
